[rtl/dq_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the double-ended queue: operation and status codes,
// word width and default capacity. No dependencies.
package dq_pkg;

  localparam int DATA_W       = 32;
  localparam int ACT_W        = 2;
  localparam int ST_W         = 2;
  localparam int DEF_CAPACITY = 8;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

[rtl/dq_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while rd_en is low. No dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

[rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on dq_pkg and dq_ram.
//
// One operation is taken per clock cycle while the output is not stalled. The
// transfer cycle updates head and count and accesses the RAM; the result and
// the registered RAM read data wait in stage 1, then in an output register
// until taken. Head index and entry count live in flip-flops and are updated
// in the cycle of the transfer; words live in one RAM with one write and one
// read port, so a pop that follows a push to the same slot in the next cycle
// reads the new word. Every operation returns one result; a rejected push or
// pop returns status full or empty, data 0 and leaves the queue unchanged.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int OUT_W = ((DATA_W + ST_W + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // push_value[31:0]
  input  logic [ACT_W-1:0]  in_tuser,   // action[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // pop_value, status, entry_count, zero pad
);

  localparam int PW = $clog2(CAPACITY);
  localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
  localparam logic [CW:0]   CAP_SUM   = (CW + 1)'(CAPACITY);

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_rd_r, s1_rd_nxt;
  logic [ST_W-1:0]   s1_status_r, s1_status_nxt;
  logic [CW-1:0]     s1_count_r, s1_count_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic [ST_W-1:0]   out_status_r;
  logic [CW-1:0]     out_count_r;

  logic              s1_adv, in_fire;
  logic              is_push, q_full, q_empty;
  logic [PW-1:0]     head_dec, head_inc, back_slot, last_slot;
  logic [CW:0]       hc_sum, hc_last;
  logic              wr_en, rd_en;
  logic [PW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign is_push = (in_tuser == ACT_PUSH_FRONT) || (in_tuser == ACT_PUSH_BACK);
  assign q_full  = (count_r == CAP_CNT);
  assign q_empty = (count_r == '0);

  assign head_dec  = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign hc_sum    = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign hc_last   = hc_sum - 1'b1;
  assign back_slot = (hc_sum >= CAP_SUM) ? PW'(hc_sum - CAP_SUM) : PW'(hc_sum);
  assign last_slot = (hc_last >= CAP_SUM) ? PW'(hc_last - CAP_SUM) : PW'(hc_last);

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_addr       = back_slot;
    rd_addr       = head_r;
    s1_rd_nxt     = 1'b0;
    s1_status_nxt = ST_OK;
    if (in_fire) begin
      if (is_push && q_full) begin
        s1_status_nxt = ST_FULL;
      end else if (!is_push && q_empty) begin
        s1_status_nxt = ST_EMPTY;
      end else begin
        case (in_tuser)
          ACT_PUSH_FRONT: begin
            head_nxt  = head_dec;
            wr_addr   = head_dec;
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          ACT_PUSH_BACK: begin
            wr_addr   = back_slot;
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          ACT_POP_FRONT: begin
            rd_addr   = head_r;
            rd_en     = 1'b1;
            s1_rd_nxt = 1'b1;
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end
          ACT_POP_BACK: begin
            rd_addr   = last_slot;
            rd_en     = 1'b1;
            s1_rd_nxt = 1'b1;
            count_nxt = count_r - 1'b1;
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
      end
    end
    s1_count_nxt = count_nxt;
    s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rd_r     <= s1_rd_nxt;
      s1_status_r <= s1_status_nxt;
      s1_count_r  <= s1_count_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_value_r  <= s1_rd_r ? rd_data : '0;
      out_status_r <= s1_status_r;
      out_count_r  <= s1_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_count_r, out_status_r, out_value_r});

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_SLOT)
    else $error("head index out of range");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_push && q_full |=> $stable(count_r) && $stable(head_r))
    else $error("rejected push changed the queue");

  a_stage_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_count_r) && $stable(rd_data))
    else $error("stalled result lost");

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("write and read issued for one operation");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for double_ended_queue: directed and random push/pop traffic with
// random stalls on both stream sides, checked by a scoreboard deque model.
// Depends on dq_pkg and the double_ended_queue RTL.
module tb;
  import dq_pkg::*;

  localparam int CAP      = DEF_CAPACITY;
  localparam int CW       = $clog2(CAP + 1);
  localparam int OUT_W    = ((DATA_W + ST_W + CW + 7) / 8) * 8;
  localparam int N_RANDOM = 1300;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [ST_W-1:0]   status;
    logic [CW-1:0]     count;
  } deq_result_t;

  class deque_scoreboard;
    logic [DATA_W-1:0] slots[CAP];
    int                head;
    int                count;
    deq_result_t       due[$];
    int                errors;
    int                n_ok;
    int                n_full;
    int                n_empty;

    function new();
      head    = 0;
      count   = 0;
      errors  = 0;
      n_ok    = 0;
      n_full  = 0;
      n_empty = 0;
    endfunction

    function void note_op(logic [ACT_W-1:0] act, logic [DATA_W-1:0] value);
      deq_result_t r;
      r.word   = '0;
      r.status = ST_OK;
      if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
        if (count >= CAP) begin
          r.status = ST_FULL;
        end else if (act == ACT_PUSH_FRONT) begin
          head        = (head + CAP - 1) % CAP;
          slots[head] = value;
          count++;
        end else begin
          slots[(head + count) % CAP] = value;
          count++;
        end
      end else begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else if (act == ACT_POP_FRONT) begin
          r.word = slots[head];
          head   = (head + 1) % CAP;
          count--;
        end else begin
          r.word = slots[(head + count - 1) % CAP];
          count--;
        end
      end
      r.count = count[CW-1:0];
      due.push_back(r);
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] data);
      deq_result_t want;
      if (due.size() == 0) begin
        report("result with nothing outstanding", data[DATA_W-1:0], '0);
        return;
      end
      want = due.pop_front();
      if (data[DATA_W-1:0] !== want.word)
        report("pop_value", data[DATA_W-1:0], want.word);
      if (data[DATA_W+ST_W-1:DATA_W] !== want.status)
        report("status", DATA_W'(data[DATA_W+ST_W-1:DATA_W]), DATA_W'(want.status));
      if (data[DATA_W+ST_W+CW-1:DATA_W+ST_W] !== want.count)
        report("entry_count", DATA_W'(data[DATA_W+ST_W+CW-1:DATA_W+ST_W]),
               DATA_W'(want.count));
      case (want.status)
        ST_FULL:  n_full++;
        ST_EMPTY: n_empty++;
        default:  n_ok++;
      endcase
    endtask

    function int pending();
      return due.size();
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;  // push_value[31:0]
  logic [ACT_W-1:0]  in_tuser   = '0;  // action[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;        // pop_value, status, entry_count, zero pad

  deque_scoreboard sb = new();
  bit              no_idle    = 1'b0;
  int              stall_left = 0;

  double_ended_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    if ($urandom_range(0, 9) != 0) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_op(logic [ACT_W-1:0] act, logic [DATA_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_op(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int               push_pct;
    logic [ACT_W-1:0] act;
    push_pct = 50;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty rejections, extremes, wrap of the head below slot zero
    send_op(ACT_POP_FRONT, 32'h1234_5678);
    send_op(ACT_POP_BACK, 32'h8765_4321);
    send_op(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_op(ACT_PUSH_FRONT, 32'h8000_0000);
    send_op(ACT_POP_BACK, '0);
    send_op(ACT_POP_FRONT, '0);
    // fill to capacity from both ends, then push into a full queue
    send_op(ACT_PUSH_FRONT, '1);
    send_op(ACT_PUSH_BACK, '0);
    send_op(ACT_PUSH_FRONT, 32'h5555_5555);
    send_op(ACT_PUSH_BACK, 32'haaaa_aaaa);
    send_op(ACT_PUSH_FRONT, 32'd1);
    send_op(ACT_PUSH_BACK, 32'd2);
    send_op(ACT_PUSH_FRONT, 32'd3);
    send_op(ACT_PUSH_BACK, 32'd4);
    send_op(ACT_PUSH_FRONT, 32'hdead_beef);
    send_op(ACT_PUSH_BACK, 32'hcafe_f00d);
    // empty it from both ends, then pop once more
    repeat (4) begin
      send_op(ACT_POP_FRONT, '0);
      send_op(ACT_POP_BACK, '1);
    end
    send_op(ACT_POP_BACK, '0);
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      if (i == N_RANDOM / 2) drain();
      if ($urandom_range(0, 99) < push_pct)
        act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      else
        act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
      send_op(act, pick_word());
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d operations: %0d accepted, %0d pushes into a full queue,",
             sb.n_ok + sb.n_full + sb.n_empty, sb.n_ok, sb.n_full);
    $display("%0d pops from an empty queue; %0d mismatches", sb.n_empty, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue.sv
sim/tb.sv
